@@ sv/dfpd_pkg.sv @@
// ----------------------------------------------------------------------------
// dfpd_pkg
// Shared types, constants and helpers for the dual-format packet deframer.
// ----------------------------------------------------------------------------
package dfpd_pkg;

	// Size of the payload store in bytes.
	localparam int PAYLOAD_CAPACITY = 32;
	// A packet gives at most this many result words.
	localparam int MAX_RESULTS      = 32;
	localparam int EFF_CAP          = (PAYLOAD_CAPACITY < MAX_RESULTS) ?
	                                  PAYLOAD_CAPACITY : MAX_RESULTS;
	localparam int ADDR_W           = $clog2(PAYLOAD_CAPACITY);
	localparam int FILL_W           = $clog2(EFF_CAP + 1);

	// Configuration register map.
	localparam int NUM_REGS    = 6;
	localparam int APB_ADDR_W  = $clog2(NUM_REGS * 4);
	localparam int REG_IDX_W   = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_HEX_START  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_HEX_END    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_HEX_LEN    = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_TEXT_START = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_TEXT_END1  = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_TEXT_END2  = REG_IDX_W'(5);

	// Reset values of the registers.
	localparam logic [7:0] RST_HEX_START  = 8'hFF;
	localparam logic [7:0] RST_HEX_END    = 8'hFE;
	localparam logic [5:0] RST_HEX_LEN    = 6'd3;
	localparam logic [7:0] RST_TEXT_START = 8'h40;
	localparam logic [7:0] RST_TEXT_END1  = 8'h2A;
	localparam logic [7:0] RST_TEXT_END2  = 8'h26;

	localparam logic KIND_HEX  = 1'b0;
	localparam logic KIND_TEXT = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEX,
		PH_HEX_END,
		PH_TEXT,
		PH_TEXT_END
	} phase_t;

	typedef struct packed {
		logic [7:0] hex_start;
		logic [7:0] hex_end;
		logic [5:0] hex_len;
		logic [7:0] text_start;
		logic [7:0] text_end1;
		logic [7:0] text_end2;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

	typedef struct packed {
		logic              valid;
		logic [FILL_W-1:0] count;
		logic              kind;
		logic              trunc;
	} pkt_done_t;

	// Hex payload length as used: zero acts as one, and it never exceeds
	// the usable part of the store.
	function automatic logic [FILL_W-1:0] hex_len_eff(input logic [5:0] len);
		logic [FILL_W-1:0] n;
		if (len == 6'd0) begin
			n = FILL_W'(1);
		end else if (int'(len) > EFF_CAP) begin
			n = FILL_W'(EFF_CAP);
		end else begin
			n = FILL_W'(len);
		end
		return n;
	endfunction

endpackage

@@ sv/dfpd_cfg.sv @@
// ----------------------------------------------------------------------------
// dfpd_cfg
// APB register file holding the framing bytes and the hex payload length.
// ----------------------------------------------------------------------------
module dfpd_cfg import dfpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hex_start  <= RST_HEX_START;
			cfg_q.hex_end    <= RST_HEX_END;
			cfg_q.hex_len    <= RST_HEX_LEN;
			cfg_q.text_start <= RST_TEXT_START;
			cfg_q.text_end1  <= RST_TEXT_END1;
			cfg_q.text_end2  <= RST_TEXT_END2;
		end else if (wr_en) begin
			unique case (idx)
				REG_HEX_START:  cfg_q.hex_start  <= pwdata[7:0];
				REG_HEX_END:    cfg_q.hex_end    <= pwdata[7:0];
				REG_HEX_LEN:    cfg_q.hex_len    <= pwdata[5:0];
				REG_TEXT_START: cfg_q.text_start <= pwdata[7:0];
				REG_TEXT_END1:  cfg_q.text_end1  <= pwdata[7:0];
				REG_TEXT_END2:  cfg_q.text_end2  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_HEX_START:  prdata = {24'd0, cfg_q.hex_start};
			REG_HEX_END:    prdata = {24'd0, cfg_q.hex_end};
			REG_HEX_LEN:    prdata = {26'd0, cfg_q.hex_len};
			REG_TEXT_START: prdata = {24'd0, cfg_q.text_start};
			REG_TEXT_END1:  prdata = {24'd0, cfg_q.text_end1};
			REG_TEXT_END2:  prdata = {24'd0, cfg_q.text_end2};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

@@ sv/dfpd_parser.sv @@
// ----------------------------------------------------------------------------
// dfpd_parser
// Framing state machine: tracks the packet phase and fill count, and issues
// store writes and packet completions.
// ----------------------------------------------------------------------------
module dfpd_parser import dfpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       take,
	input  logic [7:0] rx_byte,
	output store_wr_t  wr,
	output pkt_done_t  done
);

	phase_t            phase_q, phase_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              ovf_q, ovf_d;
	logic              room;
	logic [FILL_W-1:0] fill_inc;

	assign room     = int'(fill_q) < EFF_CAP;
	assign fill_inc = fill_q + FILL_W'(1);

	// Next state.
	always_comb begin
		phase_d = phase_q;
		fill_d  = fill_q;
		ovf_d   = ovf_q;
		if (take) begin
			unique case (phase_q)
				PH_HEX: begin
					if (room) begin
						fill_d = fill_inc;
					end
					if (fill_d >= hex_len_eff(cfg.hex_len)) begin
						phase_d = PH_HEX_END;
					end
				end
				PH_HEX_END: begin
					if (rx_byte == cfg.hex_end) begin
						phase_d = PH_IDLE;
					end
				end
				PH_TEXT: begin
					priority if (rx_byte == cfg.text_end1) begin
						phase_d = PH_TEXT_END;
					end else if (room) begin
						fill_d = fill_inc;
					end else begin
						ovf_d = 1'b1;
					end
				end
				PH_TEXT_END: begin
					if (rx_byte == cfg.text_end2) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					priority if (rx_byte == cfg.hex_start) begin
						phase_d = PH_HEX;
						fill_d  = '0;
						ovf_d   = 1'b0;
					end else if (rx_byte == cfg.text_start) begin
						phase_d = PH_TEXT;
						fill_d  = '0;
						ovf_d   = 1'b0;
					end
				end
			endcase
		end
	end

	// Outputs.
	always_comb begin
		wr.en      = 1'b0;
		wr.addr    = ADDR_W'(fill_q);
		wr.data    = rx_byte;
		done.valid = 1'b0;
		done.count = fill_q;
		done.kind  = KIND_HEX;
		done.trunc = 1'b0;
		if (take) begin
			unique case (phase_q)
				PH_HEX: begin
					wr.en = room;
				end
				PH_HEX_END: begin
					done.valid = (rx_byte == cfg.hex_end);
				end
				PH_TEXT: begin
					wr.en = room && (rx_byte != cfg.text_end1);
				end
				PH_TEXT_END: begin
					done.valid = (rx_byte == cfg.text_end2);
					done.kind  = KIND_TEXT;
					done.trunc = ovf_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fill_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			fill_q  <= fill_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

@@ sv/dfpd_drain.sv @@
// ----------------------------------------------------------------------------
// dfpd_drain
// Payload store and the read-out sequencer that turns a completed packet
// into result words, one store read per word.
// ----------------------------------------------------------------------------
module dfpd_drain import dfpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_wr_t  wr,
	input  pkt_done_t  done,
	output logic       busy,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic [4:0] payload_index,
	output logic       packet_kind,
	output logic       is_last,
	output logic       empty_packet,
	output logic       truncated
);

	logic [7:0] mem [PAYLOAD_CAPACITY];

	// Read sequencer.
	logic              active_q;
	logic [FILL_W-1:0] cnt_q;
	logic [FILL_W-1:0] k_q;
	logic              kind_q;
	logic              trunc_q;

	// Read stage.
	logic              rd_valid_s1;
	logic [7:0]        rd_data_s1;
	logic [4:0]        idx_s1;
	logic              kind_s1, last_s1, empty_s1, trunc_s1;

	// Output register.
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic [4:0]        idx_q;
	logic              out_kind_q, last_q, empty_q, out_trunc_q;

	logic              load_out;
	logic              issue;
	logic              is_empty;
	logic              issue_last;

	assign load_out   = rd_valid_s1 && (!out_valid_q || !out_stall);
	assign issue      = active_q && (!rd_valid_s1 || load_out);
	assign is_empty   = (cnt_q == '0);
	assign issue_last = is_empty || (k_q == cnt_q - FILL_W'(1));
	assign busy       = active_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[ADDR_W'(k_q)];
			idx_s1     <= 5'(k_q);
			kind_s1    <= kind_q;
			last_s1    <= issue_last;
			empty_s1   <= is_empty;
			trunc_s1   <= trunc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (done.valid) begin
				active_q <= 1'b1;
			end else if (issue && issue_last) begin
				active_q <= 1'b0;
			end
			if (issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (load_out) begin
				rd_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid) begin
			cnt_q   <= done.count;
			k_q     <= '0;
			kind_q  <= done.kind;
			trunc_q <= done.trunc;
		end else if (issue) begin
			k_q <= k_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			byte_q      <= empty_s1 ? 8'd0 : rd_data_s1;
			idx_q       <= idx_s1;
			out_kind_q  <= kind_s1;
			last_q      <= last_s1;
			empty_q     <= empty_s1;
			out_trunc_q <= trunc_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = byte_q;
	assign payload_index = idx_q;
	assign packet_kind   = out_kind_q;
	assign is_last       = last_q;
	assign empty_packet  = empty_q;
	assign truncated     = out_trunc_q;

endmodule

@@ sv/dual_format_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// dual_format_packet_deframer
// Recognises hex and text packets in a received byte stream and plays each
// completed payload out as a burst of result words.
// ----------------------------------------------------------------------------
// Each byte is taken unless the input is stalled, and a byte that does not
// complete a packet leaves the block ready for the next one at once. A hex
// packet opens with the hex start byte, carries a fixed number of payload
// bytes and then closes on the hex end byte; a text packet opens with the text
// start character, collects characters until the first end character and
// closes on the second end character. Bytes outside a packet are ignored. The
// payload is held in a single-port synchronous store of 32 bytes, which needs
// no clearing pass after reset. When the closing byte arrives, the read-out
// sequencer reads the store back one entry per cycle while the output is not
// stalled and delivers one word per payload byte, in order, with its index,
// the packet kind and a last marker; an empty text packet gives a single word
// flagged as empty, and text that overflowed the store is flagged as
// truncated on every word of its packet. While the store is being read back,
// input is stalled, and a stall on the output lengthens the read-back. The
// output word sits in a register of its own, so bytes keep flowing in while
// the final word of a packet waits to be taken. The user must write the
// configuration registers over the APB port only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dual_format_packet_deframer import dfpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// received bytes
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            rx_byte,
	// result words
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            payload_byte,
	output logic [4:0]            payload_index,
	output logic                  packet_kind,
	output logic                  is_last,
	output logic                  empty_packet,
	output logic                  truncated
);

	cfg_t      cfg;
	store_wr_t wr;
	pkt_done_t done;
	logic      busy;
	logic      take;

	// A byte is taken whenever the read-out sequencer is not using the store.
	assign in_stall = busy;
	assign take     = in_valid && !busy;

	dfpd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The parser owns the packet phase and fill count, and writes each
	// payload byte into the store as it arrives.
	dfpd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.take    (take),
		.rx_byte (rx_byte),
		.wr      (wr),
		.done    (done)
	);

	// The read-out side holds the store and plays a completed packet out.
	dfpd_drain u_drain (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr            (wr),
		.done          (done),
		.busy          (busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.packet_kind   (packet_kind),
		.is_last       (is_last),
		.empty_packet  (empty_packet),
		.truncated     (truncated)
	);

endmodule
